FILE: rtl/pchw_pkg.sv
// ----------------------------------------------------------------------------
// pchw_pkg: shared types and constants of the progress-counter hang watchdog
// Holds the register index codes, counter and register widths, reset values
// of the configuration registers and the control bundle of the trackers.
// ----------------------------------------------------------------------------
package pchw_pkg;

    // Width of every activity and loop counter.
    localparam int CNT_W = 32;

    // Width of every configuration register.
    localparam int CFG_W = 32;

    // Width of the register index on the configuration port.
    localparam int CFG_IDX_W = 3;

    // Register indexes, in the order of the register list.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNARMED_REVERT = 3'd0,
        CFG_GRACE          = 3'd1,
        CFG_CYCLE_BOUND    = 3'd2,
        CFG_SEND_BOUND     = 3'd3,
        CFG_HEALTH_BOUND   = 3'd4,
        CFG_LOOP_BOUND     = 3'd5
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_UNARMED_REVERT = 32'd600000;
    localparam logic [CFG_W-1:0] RST_GRACE          = 32'd10000;
    localparam logic [CFG_W-1:0] RST_BOUND          = 32'd5000;

    // Control bundle from the top level to each counter tracker.
    typedef struct packed {
        logic update;   // a beat leaves the input stage this cycle
        logic first;    // no baseline recorded yet
    } t_trk_ctl;

endpackage

FILE: rtl/pchw_tracker.sv
// ----------------------------------------------------------------------------
// pchw_tracker: last-movement tracker of one counter
// Keeps the last seen counter value and the time it last changed, and flags
// the counter as stale when it has not moved for longer than its bound.
// ----------------------------------------------------------------------------
module pchw_tracker #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pchw_pkg::t_trk_ctl         i_ctl,
    input  logic [pchw_pkg::CNT_W-1:0] i_value,
    input  logic [TIME_WIDTH-1:0]      i_now,
    input  logic [pchw_pkg::CFG_W-1:0] i_bound,
    output logic                       o_stale
);

    localparam int CMP_W = (TIME_WIDTH > pchw_pkg::CFG_W) ? TIME_WIDTH : pchw_pkg::CFG_W;

    logic [pchw_pkg::CNT_W-1:0] r_prev;
    logic [TIME_WIDTH-1:0]      r_at;
    logic                       w_moved;
    logic [TIME_WIDTH-1:0]      w_elapsed;

    // A baseline counts as movement at the current time.
    assign w_moved   = i_ctl.first || (i_value != r_prev);
    assign w_elapsed = i_now - r_at;

    // Movement resets the elapsed time to zero, which is never beyond a bound.
    assign o_stale = !w_moved && (CMP_W'(w_elapsed) > CMP_W'(i_bound));

    // Record the value and time of the latest movement.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_at   <= '0;
        end else if (i_ctl.update && w_moved) begin
            r_prev <= i_value;
            r_at   <= i_now;
        end
    end

endmodule

FILE: rtl/progress_counter_hang_watchdog.sv
// ----------------------------------------------------------------------------
// progress_counter_hang_watchdog: hang watchdog over progress counters
// Judges each sample of activity and loop counters against staleness bounds
// and raises one stuck flag per activity, a loop flag and an unarmed timeout.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle; the input stage and the result register
// form a two-entry pipeline, so output stalls back up only when both are full.
// Reset: synchronous, active low; clears the pipeline, the baseline flag and
// the trackers, and loads the configuration registers with their defaults.
module progress_counter_hang_watchdog #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [pchw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pchw_pkg::CFG_W-1:0]     i_cfg_data,
    // Sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [TIME_WIDTH-1:0]          i_now_time,
    input  logic [pchw_pkg::CNT_W-1:0]     i_acq_begun,
    input  logic [pchw_pkg::CNT_W-1:0]     i_acq_ended,
    input  logic [pchw_pkg::CNT_W-1:0]     i_send_begun,
    input  logic [pchw_pkg::CNT_W-1:0]     i_send_ended,
    input  logic [pchw_pkg::CNT_W-1:0]     i_health_begun,
    input  logic [pchw_pkg::CNT_W-1:0]     i_health_ended,
    input  logic [pchw_pkg::CNT_W-1:0]     i_loop_count,
    input  logic                           i_is_armed,
    input  logic [TIME_WIDTH-1:0]          i_armed_time,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_unarmed_expired,
    output logic                           o_cycle_stuck,
    output logic                           o_send_stuck,
    output logic                           o_health_stuck,
    output logic                           o_loop_stuck
);

    localparam int CMP_W = (TIME_WIDTH > pchw_pkg::CFG_W) ? TIME_WIDTH : pchw_pkg::CFG_W;

    // Configuration registers
    logic [pchw_pkg::CFG_W-1:0] r_unarmed_revert;
    logic [pchw_pkg::CFG_W-1:0] r_grace;
    logic [pchw_pkg::CFG_W-1:0] r_cycle_bound;
    logic [pchw_pkg::CFG_W-1:0] r_send_bound;
    logic [pchw_pkg::CFG_W-1:0] r_health_bound;
    logic [pchw_pkg::CFG_W-1:0] r_loop_bound;

    // Input stage
    logic                       r_s1_valid;
    logic [TIME_WIDTH-1:0]      r_s1_now;
    logic [pchw_pkg::CNT_W-1:0] r_s1_acq_b;
    logic [pchw_pkg::CNT_W-1:0] r_s1_acq_e;
    logic [pchw_pkg::CNT_W-1:0] r_s1_snd_b;
    logic [pchw_pkg::CNT_W-1:0] r_s1_snd_e;
    logic [pchw_pkg::CNT_W-1:0] r_s1_hlt_b;
    logic [pchw_pkg::CNT_W-1:0] r_s1_hlt_e;
    logic [pchw_pkg::CNT_W-1:0] r_s1_loops;
    logic                       r_s1_armed;
    logic [TIME_WIDTH-1:0]      r_s1_armed_at;

    // Baseline flag and result register
    logic r_baseline;
    logic r_out_valid;
    logic r_unarmed_expired;
    logic r_cycle_stuck;
    logic r_send_stuck;
    logic r_health_stuck;
    logic r_loop_stuck;

    // Handshake and judgment signals
    logic                  w_in_acc;
    logic                  w_s1_adv;
    pchw_pkg::t_trk_ctl    w_trk_ctl;
    logic [TIME_WIDTH-1:0] w_since_arm;
    logic                  w_in_grace;
    logic                  w_judge;
    logic                  w_acq_stale;
    logic                  w_snd_stale;
    logic                  w_hlt_stale;
    logic                  w_loop_stale;
    logic                  n_unarmed_expired;
    logic                  n_cycle_stuck;
    logic                  n_send_stuck;
    logic                  n_health_stuck;
    logic                  n_loop_stuck;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unarmed_revert <= pchw_pkg::RST_UNARMED_REVERT;
            r_grace          <= pchw_pkg::RST_GRACE;
            r_cycle_bound    <= pchw_pkg::RST_BOUND;
            r_send_bound     <= pchw_pkg::RST_BOUND;
            r_health_bound   <= pchw_pkg::RST_BOUND;
            r_loop_bound     <= pchw_pkg::RST_BOUND;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pchw_pkg::CFG_UNARMED_REVERT: r_unarmed_revert <= i_cfg_data;
                pchw_pkg::CFG_GRACE:          r_grace          <= i_cfg_data;
                pchw_pkg::CFG_CYCLE_BOUND:    r_cycle_bound    <= i_cfg_data;
                pchw_pkg::CFG_SEND_BOUND:     r_send_bound     <= i_cfg_data;
                pchw_pkg::CFG_HEALTH_BOUND:   r_health_bound   <= i_cfg_data;
                pchw_pkg::CFG_LOOP_BOUND:     r_loop_bound     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow: the input stage drains whenever the result register frees up.
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Capture an accepted sample beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_now      <= i_now_time;
            r_s1_acq_b    <= i_acq_begun;
            r_s1_acq_e    <= i_acq_ended;
            r_s1_snd_b    <= i_send_begun;
            r_s1_snd_e    <= i_send_ended;
            r_s1_hlt_b    <= i_health_begun;
            r_s1_hlt_e    <= i_health_ended;
            r_s1_loops    <= i_loop_count;
            r_s1_armed    <= i_is_armed;
            r_s1_armed_at <= i_armed_time;
        end
    end

    // Tracker control: a beat leaving the input stage updates the trackers.
    assign w_trk_ctl.update = w_s1_adv;
    assign w_trk_ctl.first  = !r_baseline;

    pchw_tracker #(.TIME_WIDTH(TIME_WIDTH)) u_trk_acq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_trk_ctl),
        .i_value (r_s1_acq_e),
        .i_now   (r_s1_now),
        .i_bound (r_cycle_bound),
        .o_stale (w_acq_stale)
    );

    pchw_tracker #(.TIME_WIDTH(TIME_WIDTH)) u_trk_send (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_trk_ctl),
        .i_value (r_s1_snd_e),
        .i_now   (r_s1_now),
        .i_bound (r_send_bound),
        .o_stale (w_snd_stale)
    );

    pchw_tracker #(.TIME_WIDTH(TIME_WIDTH)) u_trk_health (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_trk_ctl),
        .i_value (r_s1_hlt_e),
        .i_now   (r_s1_now),
        .i_bound (r_health_bound),
        .o_stale (w_hlt_stale)
    );

    pchw_tracker #(.TIME_WIDTH(TIME_WIDTH)) u_trk_loop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_trk_ctl),
        .i_value (r_s1_loops),
        .i_now   (r_s1_now),
        .i_bound (r_loop_bound),
        .o_stale (w_loop_stale)
    );

    // Judgment: unarmed timeout, grace period after arming, then staleness.
    assign w_since_arm = r_s1_now - r_s1_armed_at;
    assign w_in_grace  = CMP_W'(w_since_arm) < CMP_W'(r_grace);
    assign w_judge     = r_s1_armed && !w_in_grace;

    assign n_unarmed_expired = !r_s1_armed && (CMP_W'(r_s1_now) >= CMP_W'(r_unarmed_revert));
    assign n_cycle_stuck     = w_judge && (r_s1_acq_b != r_s1_acq_e) && w_acq_stale;
    assign n_send_stuck      = w_judge && (r_s1_snd_b != r_s1_snd_e) && w_snd_stale;
    assign n_health_stuck    = w_judge && (r_s1_hlt_b != r_s1_hlt_e) && w_hlt_stale;
    assign n_loop_stuck      = w_judge && w_loop_stale;

    // Result register and baseline flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_baseline  <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
            r_baseline  <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_unarmed_expired <= n_unarmed_expired;
            r_cycle_stuck     <= n_cycle_stuck;
            r_send_stuck      <= n_send_stuck;
            r_health_stuck    <= n_health_stuck;
            r_loop_stuck      <= n_loop_stuck;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_unarmed_expired = r_unarmed_expired;
    assign o_cycle_stuck     = r_cycle_stuck;
    assign o_send_stuck      = r_send_stuck;
    assign o_health_stuck    = r_health_stuck;
    assign o_loop_stuck      = r_loop_stuck;

    // The unarmed timeout and the stuck flags are never raised together.
    a_excl_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_unarmed_expired &&
            (r_cycle_stuck || r_send_stuck || r_health_stuck || r_loop_stuck)))
        else $error("unarmed timeout raised together with a stuck flag");

    // No result can exist before the baseline has been recorded.
    a_baseline_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_baseline |-> !r_out_valid)
        else $error("result beat before baseline");

    // The input is held off only while the input stage holds a beat.
    a_stall_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with an empty input stage");

    // A staged beat moves into an empty result register at the next edge.
    a_stage_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("staged beat did not reach the result register");

endmodule

FILE: tb/sv/progress_counter_hang_watchdog_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// progress_counter_hang_watchdog_test: self-checking bench of the hang watchdog
// Drives sample beats from a queue, keeps its own copy of the counter
// trackers and registers to predict every result beat, and compares the
// flags of each result beat in order. Covers register extremes, the grace
// window, exact stale bounds, counter and time wrap, and random traffic with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module progress_counter_hang_watchdog_test;

    localparam int CLK_PERIOD  = 10;
    localparam int QUIET_LIMIT = 400;
    localparam int REPORT_CAP  = 100;

    // Indexes past the end of the register list; writes to them are ignored.
    localparam logic [pchw_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [pchw_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [31:0]                now_time;
        logic [pchw_pkg::CNT_W-1:0] acq_begun;
        logic [pchw_pkg::CNT_W-1:0] acq_ended;
        logic [pchw_pkg::CNT_W-1:0] send_begun;
        logic [pchw_pkg::CNT_W-1:0] send_ended;
        logic [pchw_pkg::CNT_W-1:0] health_begun;
        logic [pchw_pkg::CNT_W-1:0] health_ended;
        logic [pchw_pkg::CNT_W-1:0] loop_count;
        logic                       is_armed;
        logic [31:0]                armed_time;
    } t_watch_sample;

    typedef struct packed {
        logic unarmed_expired;
        logic cycle_stuck;
        logic send_stuck;
        logic health_stuck;
        logic loop_stuck;
    } t_hang_flags;

    // Bench-side signals, all known from time zero.
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [pchw_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pchw_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [31:0]                    i_now_time = '0;
    logic [pchw_pkg::CNT_W-1:0]     i_acq_begun = '0;
    logic [pchw_pkg::CNT_W-1:0]     i_acq_ended = '0;
    logic [pchw_pkg::CNT_W-1:0]     i_send_begun = '0;
    logic [pchw_pkg::CNT_W-1:0]     i_send_ended = '0;
    logic [pchw_pkg::CNT_W-1:0]     i_health_begun = '0;
    logic [pchw_pkg::CNT_W-1:0]     i_health_ended = '0;
    logic [pchw_pkg::CNT_W-1:0]     i_loop_count = '0;
    logic                           i_is_armed = 1'b0;
    logic [31:0]                    i_armed_time = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic                           o_unarmed_expired;
    logic                           o_cycle_stuck;
    logic                           o_send_stuck;
    logic                           o_health_stuck;
    logic                           o_loop_stuck;

    progress_counter_hang_watchdog #(
        .TIME_WIDTH(32)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_now_time       (i_now_time),
        .i_acq_begun      (i_acq_begun),
        .i_acq_ended      (i_acq_ended),
        .i_send_begun     (i_send_begun),
        .i_send_ended     (i_send_ended),
        .i_health_begun   (i_health_begun),
        .i_health_ended   (i_health_ended),
        .i_loop_count     (i_loop_count),
        .i_is_armed       (i_is_armed),
        .i_armed_time     (i_armed_time),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_unarmed_expired(o_unarmed_expired),
        .o_cycle_stuck    (o_cycle_stuck),
        .o_send_stuck     (o_send_stuck),
        .o_health_stuck   (o_health_stuck),
        .o_loop_stuck     (o_loop_stuck)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow registers and trackers: 0 acquisition, 1 send, 2 health, 3 loop.
    logic [31:0] cfg_revert;
    logic [31:0] cfg_grace;
    logic [31:0] cfg_bound [0:3];
    logic        baseline_seen;
    logic [31:0] seen_end [0:3];
    logic [31:0] moved_ms [0:3];

    // Sample beats waiting to be sent and flags predicted per accepted beat.
    t_watch_sample sample_queue [$];
    t_watch_sample cur_sample;
    t_hang_flags   predicted_flags [int];
    int            samples_taken = 0;
    int            flags_seen = 0;
    int            fail_count = 0;
    int            quiet_cycles = 0;

    // Traffic generator state: one plausible system whose counters evolve.
    logic [31:0] scen_now;
    logic [31:0] scen_begun [0:2];
    logic [31:0] scen_ended [0:2];
    bit          scen_hung [0:2];
    logic [31:0] scen_loop;
    bit          scen_loop_hung;
    bit          scen_armed;
    logic [31:0] scen_armed_at;

    string flag_names [0:4] = '{"loop_stuck", "health_stuck", "send_stuck",
                                "cycle_stuck", "unarmed_expired"};

    task automatic report_mismatch(input string msg);
        if (fail_count < REPORT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Updates the trackers with one sample and returns the flags it raises.
    function automatic t_hang_flags judge_sample(input t_watch_sample s);
        logic [31:0] cur_end [0:3];
        logic [31:0] age;
        logic [3:0]  stale;
        logic [2:0]  busy;
        t_hang_flags flags;
        cur_end[0] = s.acq_ended;
        cur_end[1] = s.send_ended;
        cur_end[2] = s.health_ended;
        cur_end[3] = s.loop_count;
        busy[0] = s.acq_begun != s.acq_ended;
        busy[1] = s.send_begun != s.send_ended;
        busy[2] = s.health_begun != s.health_ended;
        flags = '0;
        // The first sample records the baseline; later ones any change.
        for (int k = 0; k < 4; k++) begin
            if (!baseline_seen || cur_end[k] != seen_end[k]) begin
                seen_end[k] = cur_end[k];
                moved_ms[k] = s.now_time;
            end
            age = s.now_time - moved_ms[k];
            stale[k] = age > cfg_bound[k];
        end
        baseline_seen = 1'b1;
        if (!s.is_armed) begin
            flags.unarmed_expired = s.now_time >= cfg_revert;
        end else begin
            age = s.now_time - s.armed_time;
            if (age >= cfg_grace) begin
                flags.cycle_stuck  = busy[0] && stale[0];
                flags.send_stuck   = busy[1] && stale[1];
                flags.health_stuck = busy[2] && stale[2];
                flags.loop_stuck   = stale[3];
            end
        end
        return flags;
    endfunction

    function automatic void queue_sample(
        input logic [31:0] now, input logic [31:0] ab, input logic [31:0] ae,
        input logic [31:0] sb, input logic [31:0] se, input logic [31:0] hb,
        input logic [31:0] he, input logic [31:0] lc, input logic armed,
        input logic [31:0] at
    );
        t_watch_sample s;
        s = '{now, ab, ae, sb, se, hb, he, lc, armed, at};
        sample_queue.push_back(s);
    endfunction

    // Mostly well-formed traffic from the evolving system, some pure noise.
    function automatic void plan_traffic(input int count, input int step_max);
        int pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 8) begin
                queue_sample($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom_range(0, 1),
                             $urandom);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    scen_now += $urandom_range(0, step_max);
                else if (pick < 92)
                    scen_now += $urandom_range(0, 4 * step_max);
                else if (pick >= 97)
                    scen_now += $urandom;
                if ($urandom_range(0, 19) == 0) begin
                    scen_armed = !scen_armed;
                    scen_armed_at = ($urandom_range(0, 3) == 0) ? $urandom : scen_now;
                end
                for (int k = 0; k < 3; k++) begin
                    if ($urandom_range(0, 14) == 0)
                        scen_hung[k] = !scen_hung[k];
                    if ($urandom_range(0, 49) == 0) begin
                        // Counter jump, with end equal to begin or one behind it.
                        scen_begun[k] = $urandom;
                        scen_ended[k] = scen_begun[k] - $urandom_range(0, 1);
                    end else if (scen_begun[k] == scen_ended[k]) begin
                        if ($urandom_range(0, 1) == 1)
                            scen_begun[k] += 1;
                    end else if (!scen_hung[k] && $urandom_range(0, 1) == 1) begin
                        scen_ended[k] += 1;
                    end
                end
                if ($urandom_range(0, 14) == 0)
                    scen_loop_hung = !scen_loop_hung;
                if (!scen_loop_hung && $urandom_range(0, 1) == 1)
                    scen_loop += $urandom_range(1, 3);
                queue_sample(scen_now, scen_begun[0], scen_ended[0], scen_begun[1],
                             scen_ended[1], scen_begun[2], scen_ended[2], scen_loop,
                             scen_armed, scen_armed_at);
            end
        end
    endfunction

    // One register write; the block is idle whenever this is called.
    task automatic write_reg(input logic [pchw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            pchw_pkg::CFG_UNARMED_REVERT: cfg_revert = value;
            pchw_pkg::CFG_GRACE:          cfg_grace = value;
            pchw_pkg::CFG_CYCLE_BOUND:    cfg_bound[0] = value;
            pchw_pkg::CFG_SEND_BOUND:     cfg_bound[1] = value;
            pchw_pkg::CFG_HEALTH_BOUND:   cfg_bound[2] = value;
            pchw_pkg::CFG_LOOP_BOUND:     cfg_bound[3] = value;
            default: ;
        endcase
    endtask

    task automatic program_all(
        input logic [31:0] revert, input logic [31:0] grace, input logic [31:0] cyc,
        input logic [31:0] snd, input logic [31:0] hlt, input logic [31:0] lp
    );
        write_reg(pchw_pkg::CFG_UNARMED_REVERT, revert);
        write_reg(pchw_pkg::CFG_GRACE, grace);
        write_reg(pchw_pkg::CFG_CYCLE_BOUND, cyc);
        write_reg(pchw_pkg::CFG_SEND_BOUND, snd);
        write_reg(pchw_pkg::CFG_HEALTH_BOUND, hlt);
        write_reg(pchw_pkg::CFG_LOOP_BOUND, lp);
    endtask

    // Waits until every queued beat was sent and every result came back.
    // Sampled at the falling edge so that all updates of the rising edge settled.
    task automatic drain();
        do
            @(negedge i_clk);
        while (sample_queue.size() != 0 || i_in_valid || samples_taken != flags_seen);
    endtask

    // Sample driver: holds a stalled beat, then waits its drawn gap.
    int in_wait = 0;
    bit in_steady = 1'b0;
    always @(posedge i_clk) begin : drive_samples
        t_watch_sample next_s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_flags[samples_taken] = judge_sample(cur_sample);
                samples_taken <= samples_taken + 1;
            end
            if (i_in_valid && o_in_stall) begin
                // Beat stalled: payload and valid stay as they are.
            end else if (in_wait > 0) begin
                in_wait--;
                i_in_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                next_s = sample_queue.pop_front();
                cur_sample      = next_s;
                i_now_time     <= next_s.now_time;
                i_acq_begun    <= next_s.acq_begun;
                i_acq_ended    <= next_s.acq_ended;
                i_send_begun   <= next_s.send_begun;
                i_send_ended   <= next_s.send_ended;
                i_health_begun <= next_s.health_begun;
                i_health_ended <= next_s.health_ended;
                i_loop_count   <= next_s.loop_count;
                i_is_armed     <= next_s.is_armed;
                i_armed_time   <= next_s.armed_time;
                i_in_valid     <= 1'b1;
                in_wait = in_steady ? 0 : $urandom_range(0, 18);
                if ($urandom_range(0, 39) == 0)
                    in_steady = !in_steady;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each result beat and draws the next stall.
    int out_wait = 0;
    bit out_steady = 1'b0;
    always @(posedge i_clk) begin : check_results
        t_hang_flags got;
        t_hang_flags want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_unarmed_expired, o_cycle_stuck, o_send_stuck,
                        o_health_stuck, o_loop_stuck};
                if (flags_seen >= samples_taken) begin
                    report_mismatch($sformatf("result beat %b with no sample waiting", got));
                end else begin
                    want = predicted_flags[flags_seen];
                    for (int b = 4; b >= 0; b--) begin
                        if (got[b] !== want[b])
                            report_mismatch($sformatf("result %0d %s got %b want %b",
                                flags_seen, flag_names[b], got[b], want[b]));
                    end
                    predicted_flags.delete(flags_seen);
                    flags_seen <= flags_seen + 1;
                end
                out_wait = out_steady ? 0 : $urandom_range(0, 18);
                if ($urandom_range(0, 29) == 0)
                    out_steady = !out_steady;
            end
            if (out_wait > 0) begin
                out_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Hang guard: too long without any beat or register write ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg_revert    = pchw_pkg::RST_UNARMED_REVERT;
        cfg_grace     = pchw_pkg::RST_GRACE;
        baseline_seen = 1'b0;
        for (int k = 0; k < 4; k++) begin
            cfg_bound[k] = pchw_pkg::RST_BOUND;
            seen_end[k]  = '0;
            moved_ms[k]  = '0;
        end
        scen_now       = '0;
        scen_loop      = '0;
        scen_loop_hung = 1'b0;
        scen_armed     = 1'b1;
        scen_armed_at  = '0;
        for (int k = 0; k < 3; k++) begin
            scen_begun[k] = '0;
            scen_ended[k] = '0;
            scen_hung[k]  = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples under the reset defaults of the registers.
        // Baseline, then the unarmed limit just below, at, and at the top of time.
        queue_sample(32'd0, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0);
        queue_sample(32'd599999, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0);
        queue_sample(32'd600000, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0);
        queue_sample('1, '1, '1, '1, '1, '1, '1, '1, 1'b0, '1);
        // Counters wrap to zero; arming time wraps, still inside the grace window.
        queue_sample(32'h1000, '0, '0, '0, '0, '0, '0, '0, 1'b1, 32'hFFFF_F000);
        // Grace just over; activities in flight but not stale yet.
        queue_sample(32'd5904, 1, 0, 1, 0, 1, 0, 0, 1'b1, 32'hFFFF_F000);
        // Age exactly at the bound, not yet stale, then one past it.
        queue_sample(32'd9096, 1, 0, 1, 0, 1, 0, 0, 1'b1, 32'hFFFF_F000);
        queue_sample(32'd9097, 1, 0, 1, 0, 1, 0, 0, 1'b1, 32'hFFFF_F000);
        // End counters and loop move; only health stays stuck.
        queue_sample(32'd9098, 1, 1, 1, 1, 1, 0, 5, 1'b1, 32'hFFFF_F000);
        // Health no longer in flight.
        queue_sample(32'd9099, 1, 1, 1, 1, 0, 0, 5, 1'b1, 32'hFFFF_F000);
        // Long stale at the top of time, then across the time wrap.
        queue_sample('1, '1, 1, '1, 1, '1, 0, 5, 1'b1, 32'd0);
        queue_sample(32'd100, '1, 1, '1, 1, '1, 0, 5, 1'b1, 32'd101);
        // Freshly armed, then unarmed early in time.
        queue_sample(32'd200, 2, 2, 2, 2, 2, 2, 6, 1'b1, 32'd200);
        queue_sample(32'd300, 2, 2, 2, 2, 2, 2, 6, 1'b0, 32'd0);
        drain();

        scen_now = 32'd400;
        plan_traffic(100, 2000);
        drain();

        // Everything at zero: any staleness counts, no grace, unarmed always out.
        program_all('0, '0, '0, '0, '0, '0);
        write_reg(CFG_SPARE_6, $urandom);
        write_reg(CFG_SPARE_7, $urandom);
        plan_traffic(100, 3);
        drain();

        // Everything at the top, with time running across its wrap.
        program_all('1, '1, '1, '1, '1, '1);
        scen_now = 32'hFFFF_FF00;
        plan_traffic(100, 40);
        drain();

        // Moderate bounds close to the traffic's time steps.
        program_all(scen_now + $urandom_range(0, 100000), $urandom_range(0, 20000),
                    $urandom_range(500, 8000), $urandom_range(500, 8000),
                    $urandom_range(500, 8000), $urandom_range(500, 8000));
        plan_traffic(100, 3000);
        drain();

        // Tight bounds with tiny time steps.
        program_all($urandom, $urandom_range(0, 40), $urandom_range(0, 60),
                    $urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(0, 60));
        write_reg(CFG_SPARE_7, $urandom);
        plan_traffic(100, 25);
        drain();

        // Random magnitudes for every register.
        program_all($urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(8, 31),
                    $urandom >> $urandom_range(12, 31), $urandom >> $urandom_range(12, 31),
                    $urandom >> $urandom_range(12, 31), $urandom >> $urandom_range(12, 31));
        plan_traffic(100, 5000);
        drain();

        // Let any stray result beat show up before the verdict.
        repeat (8) @(posedge i_clk);
        if (samples_taken != flags_seen)
            report_mismatch($sformatf("%0d results never arrived",
                samples_taken - flags_seen));
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/pchw_pkg.sv
rtl/pchw_tracker.sv
rtl/progress_counter_hang_watchdog.sv
tb/sv/progress_counter_hang_watchdog_test.sv
